// File: sv/cfr_pkg.sv
// Shared types, codes and default sizes for the clock frame replacer.
// Used by the controller, the datapath, the top level and the checker.
package cfr_pkg;

   localparam int FRAMES_DEFAULT = 64;
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ACTION_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_ACCESS = 2'd2,
      OP_EVICT  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2,
      ST_SPARE = 2'd3
   } status_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE      = 2'd0,
      ACT_SWAP      = 2'd1,
      ACT_WRITEBACK = 2'd2,
      ACT_DROP      = 2'd3
   } action_type;

   localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANON = 2'd2;

   typedef struct packed {
      logic              valid;
      logic              refd;
      logic              dirty;
      logic [KIND_W-1:0] kind;
   } flags_type;

   typedef enum logic [2:0] {
      FLAG_NONE, FLAG_INSERT, FLAG_ACCESS, FLAG_CLRREF, FLAG_ZERO
   } flag_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD, CUR_IDX, CUR_HEAD, CUR_FOLLOW
   } cur_sel_type;

   typedef enum logic [2:0] {
      RES_HOLD, RES_DONE, RES_EMPTY, RES_BAD, RES_VICTIM
   } res_sel_type;

   typedef enum logic [1:0] {
      LINK_NONE, LINK_INSERT, LINK_UNLINK
   } link_op_type;

   typedef struct packed {
      logic        accept;
      logic        clear;
      flag_op_type flag_op;
      cur_sel_type cur_sel;
      res_sel_type res_sel;
      link_op_type link_op;
      logic        steps_load;
      logic        steps_dec;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       clr_last;
      logic       idx_bad;
      logic       count_zero;
      logic       steps_zero;
      logic       fl_valid;
      logic       fl_refd;
   } stat_type;

endpackage

// File: sv/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cfr_datapath.sv
// Frame table storage, list pointers and result registers.
// Depends on cfr_pkg and cfr_ram; driven by commands from cfr_ctrl.
module cfr_datapath #(
   parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cfr_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [cfr_pkg::INDEX_W-1:0]    req_frame_index,
   input  logic [cfr_pkg::KIND_W-1:0]     req_page_kind,
   input  logic                           req_is_write,
   input  cfr_pkg::cmd_type               cmd,
   output cfr_pkg::stat_type              stat,
   output logic [cfr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cfr_pkg::INDEX_W-1:0]    rsp_victim_frame,
   output logic [cfr_pkg::ACTION_W-1:0]   rsp_victim_action,
   output logic [cfr_pkg::KIND_W-1:0]     rsp_victim_new_kind
);

   localparam int AW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);
   localparam int SW = $clog2(2 * FRAMES + 2);

   cfr_pkg::opcode_type              op_ff;
   logic [cfr_pkg::INDEX_W-1:0]      idx_ff;
   logic [cfr_pkg::KIND_W-1:0]       kind_ff;
   logic                             wr_ff;
   logic [AW-1:0]                    cur_ff, cur_in;
   logic [AW-1:0]                    head_ff, head_in;
   logic [AW-1:0]                    tail_ff, tail_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [SW-1:0]                    steps_ff;
   logic [AW-1:0]                    clr_ff;
   cfr_pkg::status_type              status_ff;
   logic [cfr_pkg::INDEX_W-1:0]      vframe_ff;
   cfr_pkg::action_type              vaction_ff;
   logic [cfr_pkg::KIND_W-1:0]       vkind_ff;

   cfr_pkg::flags_type               fl_rd, fl_wdata;
   logic                             fl_we;
   logic [AW-1:0]                    fl_waddr;
   logic [AW-1:0]                    next_rd, prev_rd;
   logic                             next_we, prev_we;
   logic [AW-1:0]                    next_waddr, next_wdata, prev_waddr, prev_wdata;
   logic                             at_head, at_tail;
   cfr_pkg::action_type              act;
   logic [cfr_pkg::KIND_W-1:0]       nkind;

   assign at_head = (cur_ff == head_ff);
   assign at_tail = (cur_ff == tail_ff);

   always_comb begin
      fl_we    = 1'b1;
      fl_waddr = cur_ff;
      fl_wdata = fl_rd;
      case (cmd.flag_op)
         cfr_pkg::FLAG_INSERT: begin
            fl_wdata = '{valid: 1'b1, refd: 1'b0, dirty: 1'b0, kind: kind_ff};
         end
         cfr_pkg::FLAG_ACCESS: begin
            fl_wdata.refd  = 1'b1;
            fl_wdata.dirty = fl_rd.dirty | wr_ff;
         end
         cfr_pkg::FLAG_CLRREF: begin
            fl_wdata.refd = 1'b0;
         end
         cfr_pkg::FLAG_ZERO: begin
            fl_wdata = '0;
         end
         default: begin
            fl_we = 1'b0;
         end
      endcase
      if (cmd.clear) begin
         fl_we    = 1'b1;
         fl_waddr = clr_ff;
         fl_wdata = '0;
      end
   end

   always_comb begin
      next_we    = 1'b0;
      prev_we    = 1'b0;
      next_waddr = prev_rd;
      next_wdata = next_rd;
      prev_waddr = next_rd;
      prev_wdata = prev_rd;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      case (cmd.link_op)
         cfr_pkg::LINK_INSERT: begin
            next_we    = (count_ff != '0);
            prev_we    = 1'b1;
            next_waddr = tail_ff;
            next_wdata = cur_ff;
            prev_waddr = cur_ff;
            prev_wdata = tail_ff;
            if (count_ff == '0) begin
               head_in = cur_ff;
            end
            tail_in  = cur_ff;
            count_in = count_ff + 1'b1;
         end
         cfr_pkg::LINK_UNLINK: begin
            next_we  = !at_head;
            prev_we  = !at_tail;
            if (at_head) begin
               head_in = next_rd;
            end
            if (at_tail) begin
               tail_in = prev_rd;
            end
            count_in = count_ff - 1'b1;
            if (count_in == '0) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (cmd.cur_sel)
         cfr_pkg::CUR_IDX:    cur_in = AW'(req_frame_index);
         cfr_pkg::CUR_HEAD:   cur_in = head_ff;
         cfr_pkg::CUR_FOLLOW: cur_in = at_tail ? head_ff : next_rd;
         default:             cur_in = cur_ff;
      endcase
   end

   always_comb begin
      if (fl_rd.kind == cfr_pkg::KIND_FILE) begin
         act   = fl_rd.dirty ? cfr_pkg::ACT_WRITEBACK : cfr_pkg::ACT_DROP;
         nkind = cfr_pkg::KIND_FILE;
      end else begin
         act   = cfr_pkg::ACT_SWAP;
         nkind = cfr_pkg::KIND_ANON;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      cur_ff <= cur_in;
      if (cmd.accept) begin
         op_ff   <= cfr_pkg::opcode_type'(req_opcode);
         idx_ff  <= req_frame_index;
         kind_ff <= req_page_kind;
         wr_ff   <= req_is_write;
      end
      if (cmd.steps_load) begin
         steps_ff <= SW'({count_ff, 1'b1});
      end else if (cmd.steps_dec) begin
         steps_ff <= steps_ff - 1'b1;
      end
      case (cmd.res_sel)
         cfr_pkg::RES_DONE, cfr_pkg::RES_EMPTY, cfr_pkg::RES_BAD: begin
            status_ff  <= (cmd.res_sel == cfr_pkg::RES_DONE)  ? cfr_pkg::ST_DONE :
                          (cmd.res_sel == cfr_pkg::RES_EMPTY) ? cfr_pkg::ST_EMPTY :
                                                                cfr_pkg::ST_BAD;
            vframe_ff  <= '0;
            vaction_ff <= cfr_pkg::ACT_NONE;
            vkind_ff   <= '0;
         end
         cfr_pkg::RES_VICTIM: begin
            status_ff  <= cfr_pkg::ST_DONE;
            vframe_ff  <= cfr_pkg::INDEX_W'(cur_ff);
            vaction_ff <= act;
            vkind_ff   <= nkind;
         end
         default: begin
         end
      endcase
   end

   cfr_ram #(.WIDTH($bits(cfr_pkg::flags_type)), .DEPTH(FRAMES)) u_flags (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_addr (cur_in),
      .rd_data (fl_rd)
   );

   cfr_ram #(.WIDTH(AW), .DEPTH(FRAMES)) u_next (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (cur_in),
      .rd_data (next_rd)
   );

   cfr_ram #(.WIDTH(AW), .DEPTH(FRAMES)) u_prev (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (cur_in),
      .rd_data (prev_rd)
   );

   assign stat.op         = op_ff;
   assign stat.clr_last   = (clr_ff == AW'(FRAMES - 1));
   assign stat.idx_bad    = (int'(idx_ff) >= FRAMES);
   assign stat.count_zero = (count_ff == '0);
   assign stat.steps_zero = (steps_ff == '0);
   assign stat.fl_valid   = fl_rd.valid;
   assign stat.fl_refd    = fl_rd.refd;

   assign rsp_status          = status_ff;
   assign rsp_victim_frame    = vframe_ff;
   assign rsp_victim_action   = vaction_ff;
   assign rsp_victim_new_kind = vkind_ff;

endmodule

// File: sv/cfr_ctrl.sv
// Sequencing state machine for the clock frame replacer.
// Depends on cfr_pkg; issues commands to cfr_datapath and reads its status.
module cfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  cfr_pkg::stat_type  stat,
   output cfr_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_CHK, S_UNLINK, S_ERD, S_ECHK, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{accept: 1'b0, clear: 1'b0, flag_op: cfr_pkg::FLAG_NONE,
                   cur_sel: cfr_pkg::CUR_HOLD, res_sel: cfr_pkg::RES_HOLD,
                   link_op: cfr_pkg::LINK_NONE, steps_load: 1'b0, steps_dec: 1'b0};
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.cur_sel = cfr_pkg::CUR_IDX;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            if (stat.op == cfr_pkg::OP_EVICT) begin
               if (stat.count_zero) begin
                  cmd.res_sel = cfr_pkg::RES_EMPTY;
                  state_in    = S_RESP;
               end else begin
                  cmd.cur_sel    = cfr_pkg::CUR_HEAD;
                  cmd.steps_load = 1'b1;
                  state_in       = S_ERD;
               end
            end else if (stat.idx_bad) begin
               cmd.res_sel = cfr_pkg::RES_BAD;
               state_in    = S_RESP;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_RESP;
            if ((stat.op == cfr_pkg::OP_INSERT) == stat.fl_valid) begin
               cmd.res_sel = cfr_pkg::RES_BAD;
            end else begin
               cmd.res_sel = cfr_pkg::RES_DONE;
               case (stat.op)
                  cfr_pkg::OP_INSERT: begin
                     cmd.flag_op = cfr_pkg::FLAG_INSERT;
                     cmd.link_op = cfr_pkg::LINK_INSERT;
                  end
                  cfr_pkg::OP_ACCESS: begin
                     cmd.flag_op = cfr_pkg::FLAG_ACCESS;
                  end
                  default: begin
                     state_in = S_UNLINK;
                  end
               endcase
            end
         end
         S_UNLINK: begin
            cmd.flag_op = cfr_pkg::FLAG_ZERO;
            cmd.link_op = cfr_pkg::LINK_UNLINK;
            state_in    = S_RESP;
         end
         S_ERD: begin
            state_in = S_ECHK;
         end
         S_ECHK: begin
            if (stat.steps_zero) begin
               cmd.res_sel = cfr_pkg::RES_EMPTY;
               state_in    = S_RESP;
            end else begin
               cmd.steps_dec = 1'b1;
               if (stat.fl_refd) begin
                  cmd.flag_op = cfr_pkg::FLAG_CLRREF;
                  cmd.cur_sel = cfr_pkg::CUR_FOLLOW;
                  state_in    = S_ERD;
               end else begin
                  cmd.res_sel = cfr_pkg::RES_VICTIM;
                  state_in    = S_UNLINK;
               end
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// File: sv/clock_frame_replacer_core.sv
// Clock (second-chance) frame replacer: top level joining controller and datapath.
// Path from the accepting edge to the result word: insert, access and absent or present frame
// pass LOOK and CHK; remove adds UNLINK; a bad index or an evict on an empty table leaves from
// LOOK; evict passes ERD and ECHK per frame and UNLINK, at most 2*entries+1 frames examined.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// Reset: synchronous, active high; a clearing pass over all FRAMES entries follows. Uses cfr_pkg.
module clock_frame_replacer_core #(
   parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [cfr_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [cfr_pkg::INDEX_W-1:0]  req_frame_index,
   input  logic [cfr_pkg::KIND_W-1:0]   req_page_kind,
   input  logic                         req_is_write,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cfr_pkg::STATUS_W-1:0] rsp_status,
   output logic [cfr_pkg::INDEX_W-1:0]  rsp_victim_frame,
   output logic [cfr_pkg::ACTION_W-1:0] rsp_victim_action,
   output logic [cfr_pkg::KIND_W-1:0]   rsp_victim_new_kind
);

   cfr_pkg::cmd_type  cmd;
   cfr_pkg::stat_type stat;

   cfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfr_datapath #(.FRAMES(FRAMES)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_frame_index     (req_frame_index),
      .req_page_kind       (req_page_kind),
      .req_is_write        (req_is_write),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_victim_action   (rsp_victim_action),
      .rsp_victim_new_kind (rsp_victim_new_kind)
   );

endmodule

// File: sv/cfr_checker.sv
// Port-level checks for the clock frame replacer, bound to the top level.
// Depends on cfr_pkg.
module cfr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cfr_pkg::STATUS_W-1:0] rsp_status,
   input logic [cfr_pkg::INDEX_W-1:0]  rsp_victim_frame,
   input logic [cfr_pkg::ACTION_W-1:0] rsp_victim_action,
   input logic [cfr_pkg::KIND_W-1:0]   rsp_victim_new_kind
);

   localparam logic [cfr_pkg::STATUS_W-1:0] DONE = cfr_pkg::ST_DONE;
   localparam logic [cfr_pkg::ACTION_W-1:0] NONE = cfr_pkg::ACT_NONE;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after taking a word");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("word taken while a result waits");

   a_failed_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != DONE |->
         rsp_victim_action == NONE && rsp_victim_frame == '0 && rsp_victim_new_kind == '0)
      else $error("failed request reports a victim");

endmodule

bind clock_frame_replacer_core cfr_checker u_cfr_checker (.*);
